// File: rtl/core/bfa_pkg.sv
package bfa_pkg;

	// default number of slots in the bitmap
	localparam int BFA_SLOTS = 16;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_NO_SPACE    = 2'd1,
		STAT_DOUBLE_FREE = 2'd2,
		STAT_RANGE_ERROR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t       command;
		logic [4:0] count;
		logic [3:0] start_index;
	} bfa_req_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] granted_index;
		logic       all_free;
	} bfa_res_t;

endpackage

// File: rtl/core/bfa_map_ram.sv
module bfa_map_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/bfa_engine.sv
module bfa_engine #(
	parameter int SLOTS = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bfa_pkg::bfa_req_t req,
	output logic              res_valid,
	input  logic              res_ack,
	output bfa_pkg::bfa_res_t res,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic              ram_wdata,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr,
	input  logic              ram_rdata
);

	import bfa_pkg::*;

	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = (CW > 6) ? CW : 6;
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	state_t        state_q, state_d;
	logic [AW-1:0] rd_addr_q;
	logic          issue_q;
	logic [4:0]    iss_left_q;
	logic          rd_pend_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [4:0]    run_q;
	logic [AW-1:0] run_start_q;
	logic [4:0]    cnt_q;
	logic [4:0]    proc_q;
	logic [AW-1:0] wr_addr_q;
	logic [CW-1:0] used_q;
	status_t       status_q;
	logic [3:0]    granted_q;

	logic          alloc_bad;
	logic          free_bad;
	logic          free_zero;
	logic          blk_free;
	logic [4:0]    run_inc;
	logic          found;
	logic          scan_last;
	logic [AW-1:0] seg_start;
	logic          free_hit;

	// request decode
	assign alloc_bad = (req.count == 5'd0) || (EW'(req.count) > EW'(SLOTS));
	assign free_bad  = (EW'(req.start_index) + EW'(req.count)) > EW'(SLOTS);
	assign free_zero = (req.count == 5'd0);

	// run tracking on the slot that just came back from the map
	assign blk_free  = !ram_rdata;
	assign run_inc   = run_q + 5'd1;
	assign seg_start = (run_q == 5'd0) ? rd_idx_s1 : run_start_q;
	assign found     = (state_q == ST_SCAN) && rd_pend_s1 && blk_free && (run_inc == cnt_q);
	assign scan_last = (rd_idx_s1 == LAST);
	assign free_hit  = (state_q == ST_FREE) && rd_pend_s1 && blk_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (wr_addr_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req.command == CMD_ALLOC) begin
						state_d = alloc_bad ? ST_DONE : ST_SCAN;
					end else begin
						state_d = (free_bad || free_zero) ? ST_DONE : ST_FREE;
					end
				end
			end
			ST_SCAN: begin
				if (found) begin
					state_d = ST_MARK;
				end else if (rd_pend_s1 && scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_MARK: begin
				if (proc_q == 5'd1) begin
					state_d = ST_DONE;
				end
			end
			ST_FREE: begin
				if (rd_pend_s1 && (blk_free || proc_q == 5'd1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ack) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = wr_addr_q;
		ram_wdata = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_SCAN: begin
				ram_re = issue_q && !found;
			end
			ST_MARK: begin
				ram_we    = 1'b1;
				ram_wdata = 1'b1;
			end
			ST_FREE: begin
				ram_re    = (iss_left_q != 5'd0) && !free_hit;
				ram_we    = rd_pend_s1 && !blk_free;
				ram_waddr = rd_idx_s1;
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	assign res.status        = status_q;
	assign res.granted_index = granted_q;
	assign res.all_free      = (used_q == '0);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			wr_addr_q  <= '0;
			used_q     <= '0;
			issue_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= ram_re;
			case (state_q)
				ST_CLEAR: begin
					wr_addr_q <= (wr_addr_q == LAST) ? '0 : wr_addr_q + 1'b1;
				end
				ST_IDLE: begin
					issue_q <= req_valid && (req.command == CMD_ALLOC);
				end
				ST_SCAN: begin
					if (ram_re && rd_addr_q == LAST) begin
						issue_q <= 1'b0;
					end
					if (found) begin
						wr_addr_q <= seg_start;
						used_q    <= used_q + CW'(cnt_q);
					end
				end
				ST_MARK: begin
					wr_addr_q <= wr_addr_q + 1'b1;
				end
				ST_FREE: begin
					if (ram_we) begin
						used_q <= used_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_idx_s1 <= rd_addr_q;
		end
		case (state_q)
			ST_IDLE: begin
				cnt_q      <= req.count;
				proc_q     <= req.count;
				iss_left_q <= req.count;
				run_q      <= '0;
				granted_q  <= '0;
				if (req.command == CMD_ALLOC) begin
					rd_addr_q <= '0;
					status_q  <= alloc_bad ? STAT_NO_SPACE : STAT_OK;
				end else begin
					rd_addr_q <= AW'(req.start_index);
					status_q  <= free_bad ? STAT_RANGE_ERROR : STAT_OK;
				end
			end
			ST_SCAN: begin
				if (ram_re) begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
				if (rd_pend_s1) begin
					run_q       <= blk_free ? run_inc : 5'd0;
					run_start_q <= seg_start;
					if (found) begin
						granted_q <= 4'(seg_start);
						proc_q    <= cnt_q;
					end else if (scan_last) begin
						status_q <= STAT_NO_SPACE;
					end
				end
			end
			ST_MARK: begin
				proc_q <= proc_q - 5'd1;
			end
			ST_FREE: begin
				if (ram_re) begin
					rd_addr_q  <= rd_addr_q + 1'b1;
					iss_left_q <= iss_left_q - 5'd1;
				end
				if (rd_pend_s1) begin
					if (blk_free) begin
						status_q <= STAT_DOUBLE_FREE;
					end else begin
						proc_q <= proc_q - 5'd1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/bitmap_first_fit_allocator.sv
// allocate runs through scan, mark and done from accept to result
// free runs through free and done; a request rejected at decode goes straight to done
// throughput: one item at a time, set by the single-bit map memory port (one slot per cycle)
// reset: arst_n clears control at once, then a clearing pass zeroes every slot of the map
// while s_tready stays low; the result register lets a new item start while a result waits
module bitmap_first_fit_allocator #(
	parameter int SLOTS = bfa_pkg::BFA_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // count[4:0], start_index[8:5], zero fill
	input  logic        s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // status[1:0], granted_index[5:2], all_free[6], zero fill
);

	import bfa_pkg::*;

	localparam int AW = $clog2(SLOTS);

	bfa_req_t      req;
	bfa_res_t      res;
	bfa_res_t      out_q;
	logic          out_valid_q;
	logic          res_valid;
	logic          res_ack;

	// map memory port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic          ram_rdata;

	// unpack the incoming item
	assign req.command     = cmd_t'(s_tuser);
	assign req.count       = s_tdata[4:0];
	assign req.start_index = s_tdata[8:5];

	// the engine owns the map: it scans, marks and clears slots one per cycle
	bfa_engine #(
		.SLOTS (SLOTS),
		.AW    (AW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ack   (res_ack),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// one bit per slot, 1 = used; reads return the next cycle
	bfa_map_ram #(
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register: takes a finished result whenever it is empty or being drained
	assign res_ack = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.all_free, out_q.granted_index, out_q.status};

endmodule

// File: sim/bitmap_first_fit_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_first_fit_allocator_test;

	import bfa_pkg::*;

	localparam int SLOTS = BFA_SLOTS;
	// cycles with no item accepted on either side before the run is called hung
	localparam int WATCHDOG_LIMIT = 2000;
	// long receiver hold-off, well past what the block can buffer
	localparam int OUTPUT_HOLD_CYCLES = 150;
	// worst allocate latency plus margin, waited out at the end
	localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
	localparam int MAX_PRINTED = 50;

	// one predicted result item
	typedef struct {
		status_t    status;
		logic [3:0] granted;
		logic       all_free;
	} grant_result_t;

	// a run of slots handed out by the block and not yet returned
	typedef struct {
		logic [3:0] base;
		logic [4:0] len;
	} slot_run_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // count[4:0], start_index[8:5], zero fill
	logic        s_tuser;  // command
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // status[1:0], granted_index[5:2], all_free[6], zero fill

	// predictor copy of the bitmap, 1 = used
	logic [SLOTS-1:0] slot_used;
	grant_result_t    predicted_results[$];
	slot_run_t        live_runs[$];
	grant_result_t    checked_result;

	int  mismatch_count;
	int  result_number;
	int  quiet_cycles;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_request;

	bitmap_first_fit_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// first fit over the predictor bitmap, then update it the way the block does
	function automatic grant_result_t predict_request(input cmd_t cmd, input logic [4:0] cnt,
		input logic [3:0] start);
		grant_result_t res;
		int run;
		int run_base;
		int k;
		bit stop;
		res.status  = STAT_NO_SPACE;
		res.granted = '0;
		run = 0;
		run_base = 0;
		stop = 1'b0;
		if (cmd == CMD_ALLOC) begin
			// zero or oversize requests never find a run
			if (cnt != 0 && int'(cnt) <= SLOTS) begin
				for (k = 0; k < SLOTS && !stop; k++) begin
					if (!slot_used[k]) begin
						if (run == 0)
							run_base = k;
						run++;
						if (run == int'(cnt)) begin
							for (int m = run_base; m <= k; m++)
								slot_used[m] = 1'b1;
							res.status  = STAT_OK;
							res.granted = 4'(run_base);
							stop = 1'b1;
						end
					end else begin
						run = 0;
					end
				end
			end
		end else if (int'(start) + int'(cnt) > SLOTS) begin
			// a free past the end touches nothing
			res.status = STAT_RANGE_ERROR;
		end else begin
			// clear in ascending order, stop at the first slot already free
			res.status = STAT_OK;
			for (k = int'(start); k < int'(start) + int'(cnt) && !stop; k++) begin
				if (!slot_used[k]) begin
					res.status = STAT_DOUBLE_FREE;
					stop = 1'b1;
				end else begin
					slot_used[k] = 1'b0;
				end
			end
		end
		res.all_free = (slot_used == '0);
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED)
			$display("result %0d at %0t: %s", result_number, $realtime, what);
		mismatch_count++;
	endtask

	// offer one request item, wait for the handshake, hand back its prediction
	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input cmd_t cmd, input logic [4:0] cnt, input logic [3:0] start,
		output grant_result_t res);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {7'b0, start, cnt};
		do
			@(posedge clk);
		while (!s_tready);
		res = predict_request(cmd, cnt, start);
		predicted_results.push_back(res);
		@(negedge clk);
	endtask

	// result checker: every accepted result item against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			result_number++;
			if (predicted_results.size() == 0) begin
				report_mismatch($sformatf("result item 0x%02h with nothing outstanding", m_tdata));
			end else begin
				checked_result = predicted_results.pop_front();
				if (m_tdata[1:0] !== checked_result.status)
					report_mismatch($sformatf("status %0d, predicted %s", m_tdata[1:0],
						checked_result.status.name()));
				if (m_tdata[5:2] !== checked_result.granted)
					report_mismatch($sformatf("granted_index %0d, predicted %0d", m_tdata[5:2],
						checked_result.granted));
				if (m_tdata[6] !== checked_result.all_free)
					report_mismatch($sformatf("all_free %b, predicted %b", m_tdata[6],
						checked_result.all_free));
			end
		end
	end

	// receiver: random ready bursts, plus a long hold-off when asked
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready = 1'b0;
				repeat (OUTPUT_HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// field extremes, every command and each corner of the bitmap rules
	task automatic test_directed_cases;
		grant_result_t res;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_item(CMD_ALLOC, 5'd0,  4'd0,  res);  // zero-size allocate
		send_item(CMD_ALLOC, 5'd16, 4'd15, res);  // whole bitmap in one run
		send_item(CMD_ALLOC, 5'd1,  4'd0,  res);  // full map, no space
		send_item(CMD_FREE,  5'd16, 4'd0,  res);  // free everything
		send_item(CMD_ALLOC, 5'd17, 4'd0,  res);  // larger than the map
		send_item(CMD_ALLOC, 5'd31, 4'd15, res);  // largest count field
		send_item(CMD_FREE,  5'd2,  4'd15, res);  // runs past the end
		send_item(CMD_FREE,  5'd0,  4'd0,  res);  // zero-size free
		send_item(CMD_FREE,  5'd0,  4'd15, res);  // zero-size free at the top slot
		send_item(CMD_FREE,  5'd1,  4'd3,  res);  // free of a slot not in use
		send_item(CMD_ALLOC, 5'd4,  4'd0,  res);
		send_item(CMD_ALLOC, 5'd4,  4'd0,  res);
		send_item(CMD_ALLOC, 5'd8,  4'd0,  res);  // fills the map exactly
		send_item(CMD_FREE,  5'd4,  4'd4,  res);  // hole in the middle
		send_item(CMD_ALLOC, 5'd2,  4'd9,  res);  // first fit lands in the hole
		send_item(CMD_FREE,  5'd8,  4'd0,  res);  // partial clear, then double free
		send_item(CMD_ALLOC, 5'd3,  4'd0,  res);
		send_item(CMD_FREE,  5'd1,  4'd15, res);  // top slot alone
		send_item(CMD_ALLOC, 5'd6,  4'd0,  res);  // free slots exist, no run long enough
		send_item(CMD_ALLOC, 5'd5,  4'd0,  res);
		send_item(CMD_FREE,  5'd15, 4'd0,  res);  // back to an empty map
		send_item(CMD_FREE,  5'd3,  4'd14, res);
		send_item(CMD_FREE,  5'd16, 4'd15, res);  // far past the end
		send_item(CMD_ALLOC, 5'd1,  4'd7,  res);
		send_item(CMD_FREE,  5'd1,  4'd0,  res);
	endtask

	// mostly allocate and return real runs, with some malformed frees mixed in
	task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
		grant_result_t res;
		int unsigned pick;
		int idx;
		int cut;
		int k;
		bit intact;
		logic [4:0] cnt;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 50 || (live_runs.size() == 0 && pick < 90)) begin
				// sizes lean small so the map churns, with odd sizes now and then
				pick = $urandom_range(0, 99);
				if (pick < 65)
					cnt = 5'($urandom_range(1, 4));
				else if (pick < 88)
					cnt = 5'($urandom_range(5, 16));
				else if (pick < 93)
					cnt = 5'd0;
				else
					cnt = 5'($urandom_range(17, 31));
				// start_index is ignored here, so any value will do
				send_item(CMD_ALLOC, cnt, 4'($urandom), res);
				if (res.status == STAT_OK)
					live_runs.push_back('{base: res.granted, len: cnt});
			end else if (pick < 90) begin
				// return a live run whole, or just its leading part
				idx = $urandom_range(0, live_runs.size() - 1);
				if ($urandom_range(0, 2) == 0)
					cut = $urandom_range(1, live_runs[idx].len);
				else
					cut = live_runs[idx].len;
				send_item(CMD_FREE, 5'(cut), live_runs[idx].base, res);
				if (cut == live_runs[idx].len) begin
					live_runs.delete(idx);
				end else begin
					live_runs[idx].base = live_runs[idx].base + 4'(cut);
					live_runs[idx].len  = live_runs[idx].len - 5'(cut);
				end
			end else begin
				// arbitrary free: double frees and range errors
				send_item(CMD_FREE, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)), res);
			end
			// forget runs that a stray free has eaten into
			for (idx = live_runs.size() - 1; idx >= 0; idx--) begin
				intact = 1'b1;
				for (k = 0; k < int'(live_runs[idx].len); k++)
					if (!slot_used[int'(live_runs[idx].base) + k])
						intact = 1'b0;
				if (!intact)
					live_runs.delete(idx);
			end
		end
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_output_stall;
		hold_request = 1'b1;
		test_random_traffic(12, 0, 0);
		wait (!hold_request);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = CMD_ALLOC;
		slot_used     = '0;
		hold_request  = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases;
		test_random_traffic(300, 20, 20);
		test_output_stall;
		test_random_traffic(250, 50, 50);
		test_output_stall;
		// closing stretch with both sides always ready
		test_random_traffic(330, 0, 0);

		s_tvalid = 1'b0;
		wait (predicted_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
